// ----- rtl/dma_channel_address_sequencer_top_assert.svh -----
// Assertion macros for the DMA channel address sequencer.
// Included by the top level; relies on clk_i and rst_ni being in scope.
`ifndef DMA_CHANNEL_ADDRESS_SEQUENCER_TOP_ASSERT_SVH
`define DMA_CHANNEL_ADDRESS_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DMAS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmas assertion failed");

// Next-cycle implication, checked outside reset.
`define DMAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmas assertion failed");

`endif

// ----- rtl/dmas_pkg.sv -----
// Package for the DMA channel address sequencer: beat, result and state types,
// control word field positions and count constants. No dependencies.
`timescale 1ns / 1ps

package dmas_pkg;

  localparam int Channels = 4;
  localparam int ChanW    = 2;
  localparam int AddrBits = 28;
  localparam int CountW   = 17;
  localparam int CtlW     = 32;

  // Control word layout: count in the low half, flags in the high half.
  localparam int CountLsb   = 0;
  localparam int CountMsb   = 15;
  localparam int DestLsb    = 16 + 5;
  localparam int DestMsb    = 16 + 6;
  localparam int SrcLsb     = 16 + 7;
  localparam int SrcMsb     = 16 + 8;
  localparam int RepeatBit  = 16 + 9;
  localparam int Word32Bit  = 16 + 10;
  localparam int TimingLsb  = 16 + 12;
  localparam int TimingMsb  = 16 + 13;
  localparam int EnableBit  = 16 + 15;

  localparam logic [CountW-1:0] CountDefault = 17'h04000;
  localparam logic [CountW-1:0] CountLastCh  = 17'h10000;
  localparam logic [ChanW-1:0]  LongCountCh  = 2'd3;

  typedef enum logic [1:0] {
    ModeSet     = 2'd0,
    ModeStop    = 2'd1,
    ModeTrigger = 2'd2,
    ModeStep    = 2'd3
  } dmas_mode_e;

  typedef enum logic [1:0] {
    TimingImmediate = 2'd0,
    TimingVblank    = 2'd1,
    TimingHblank    = 2'd2,
    TimingSpecial   = 2'd3
  } dmas_timing_e;

  typedef enum logic [1:0] {
    DestInc    = 2'd0,
    DestDec    = 2'd1,
    DestFixed  = 2'd2,
    DestReload = 2'd3
  } dmas_dest_mode_e;

  typedef enum logic [1:0] {
    SrcInc      = 2'd0,
    SrcDec      = 2'd1,
    SrcFixed    = 2'd2,
    SrcFixedAlt = 2'd3
  } dmas_src_mode_e;

  typedef struct packed {
    dmas_mode_e           mode;
    logic [ChanW-1:0]     channel;
    logic [AddrBits-1:0]  src_addr;
    logic [AddrBits-1:0]  dest_addr;
    logic [CtlW-1:0]      control_word;
    dmas_timing_e         start_trigger;
  } dmas_item_t;

  typedef struct packed {
    logic                 xfer_valid;
    logic [ChanW-1:0]     xfer_channel;
    logic [AddrBits-1:0]  read_addr;
    logic [AddrBits-1:0]  write_addr;
    logic                 word_32;
    logic                 last_of_block;
    logic                 enable_cleared;
    logic                 busy_res;
  } dmas_result_t;

  typedef struct packed {
    logic [Channels-1:0][AddrBits-1:0] src;
    logic [Channels-1:0][AddrBits-1:0] dst;
    logic [Channels-1:0][CtlW-1:0]     ctl;
    logic [Channels-1:0]               active;
    logic [Channels-1:0]               pending;
    logic                              running;
    logic [ChanW-1:0]                  run_ch;
    logic [CountW-1:0]                 remaining;
    logic [AddrBits-1:0]               work_src;
    logic [AddrBits-1:0]               work_dst;
  } dmas_state_t;

endpackage

// ----- rtl/dmas_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
// Depends on dmas_pkg.
`timescale 1ns / 1ps

interface dmas_in_if;
  logic                  valid;
  logic                  ready;
  dmas_pkg::dmas_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dmas_out_if;
  logic                   valid;
  logic                   ready;
  dmas_pkg::dmas_result_t result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

// ----- rtl/dmas_step.sv -----
// Next-state and result logic for one command beat of the DMA sequencer.
// Purely combinational; depends on dmas_pkg.
`timescale 1ns / 1ps

module dmas_step (
  input  dmas_pkg::dmas_item_t   item_i,
  input  dmas_pkg::dmas_state_t  state_i,
  output dmas_pkg::dmas_state_t  state_o,
  output dmas_pkg::dmas_result_t result_o
);

  logic [dmas_pkg::Channels-1:0] consumed;
  logic [dmas_pkg::Channels-1:0] kill;
  logic                          pick_found;
  logic [dmas_pkg::ChanW-1:0]    pick_ch;
  logic [dmas_pkg::CountW-1:0]   pick_count;
  logic [15:0]                   pick_raw;

  // Priority scan over pending channels, lowest first. Channels with a zero
  // address ahead of the winner are retired in the same beat.
  always_comb begin
    consumed   = '0;
    kill       = '0;
    pick_found = 1'b0;
    pick_ch    = '0;
    for (int c = 0; c < dmas_pkg::Channels; c++) begin
      if (!pick_found && state_i.pending[c]) begin
        consumed[c] = 1'b1;
        if (state_i.active[c] && state_i.ctl[c][dmas_pkg::EnableBit]) begin
          if (state_i.src[c] == '0 || state_i.dst[c] == '0) begin
            kill[c] = 1'b1;
          end else begin
            pick_found = 1'b1;
            pick_ch    = dmas_pkg::ChanW'(c);
          end
        end
      end
    end
  end

  always_comb begin
    pick_raw = state_i.ctl[pick_ch][dmas_pkg::CountMsb:dmas_pkg::CountLsb];
    if (pick_raw != '0) begin
      pick_count = {1'b0, pick_raw};
    end else if (pick_ch == dmas_pkg::LongCountCh) begin
      pick_count = dmas_pkg::CountLastCh;
    end else begin
      pick_count = dmas_pkg::CountDefault;
    end
  end

  logic [dmas_pkg::CtlW-1:0]     cur_ctl;
  logic [2:0]                    unit;
  logic [dmas_pkg::AddrBits-1:0] unit_ext;
  logic [dmas_pkg::AddrBits-1:0] next_src;
  logic [dmas_pkg::AddrBits-1:0] next_dst;
  logic [dmas_pkg::CountW-1:0]   next_rem;
  dmas_pkg::dmas_src_mode_e      src_mode;
  dmas_pkg::dmas_dest_mode_e     dst_mode;
  dmas_pkg::dmas_state_t         s;
  dmas_pkg::dmas_result_t        r;

  always_comb begin
    s        = state_i;
    r        = '0;
    cur_ctl  = '0;
    unit     = 3'd2;
    unit_ext = '0;
    next_src = '0;
    next_dst = '0;
    next_rem = '0;
    src_mode = dmas_pkg::SrcInc;
    dst_mode = dmas_pkg::DestInc;

    unique case (item_i.mode)
      dmas_pkg::ModeSet: begin
        if (int'(item_i.channel) < dmas_pkg::Channels) begin
          if (s.running && s.run_ch == item_i.channel) begin
            s.running = 1'b0;
          end
          s.src[item_i.channel]     = item_i.src_addr;
          s.dst[item_i.channel]     = item_i.dest_addr;
          s.ctl[item_i.channel]     = item_i.control_word;
          s.active[item_i.channel]  = item_i.control_word[dmas_pkg::EnableBit];
          s.pending[item_i.channel] = item_i.control_word[dmas_pkg::EnableBit] &&
              (item_i.control_word[dmas_pkg::TimingMsb:dmas_pkg::TimingLsb] ==
               dmas_pkg::TimingImmediate);
        end
      end
      dmas_pkg::ModeStop: begin
        if (int'(item_i.channel) < dmas_pkg::Channels) begin
          if (s.running && s.run_ch == item_i.channel) begin
            s.running = 1'b0;
          end
          s.active[item_i.channel]  = 1'b0;
          s.ctl[item_i.channel]     = '0;
          s.pending[item_i.channel] = 1'b0;
        end
      end
      dmas_pkg::ModeTrigger: begin
        for (int c = 0; c < dmas_pkg::Channels; c++) begin
          if (s.active[c] && s.ctl[c][dmas_pkg::TimingMsb:dmas_pkg::TimingLsb] ==
              item_i.start_trigger) begin
            s.pending[c] = 1'b1;
          end
        end
      end
      dmas_pkg::ModeStep: begin
        if (!s.running) begin
          s.pending = s.pending & ~consumed;
          s.active  = s.active & ~kill;
          if (pick_found) begin
            s.running   = 1'b1;
            s.run_ch    = pick_ch;
            s.remaining = pick_count;
            s.work_src  = s.src[pick_ch];
            s.work_dst  = s.dst[pick_ch];
          end
        end
        if (s.running) begin
          cur_ctl  = s.ctl[s.run_ch];
          unit     = cur_ctl[dmas_pkg::Word32Bit] ? 3'd4 : 3'd2;
          unit_ext = {{(dmas_pkg::AddrBits-3){1'b0}}, unit};
          src_mode = dmas_pkg::dmas_src_mode_e'(cur_ctl[dmas_pkg::SrcMsb:dmas_pkg::SrcLsb]);
          dst_mode = dmas_pkg::dmas_dest_mode_e'(cur_ctl[dmas_pkg::DestMsb:dmas_pkg::DestLsb]);

          r.xfer_valid   = 1'b1;
          r.xfer_channel = s.run_ch;
          r.read_addr    = s.work_src;
          r.write_addr   = s.work_dst;
          r.word_32      = cur_ctl[dmas_pkg::Word32Bit];

          unique case (src_mode)
            dmas_pkg::SrcInc:      next_src = s.work_src + unit_ext;
            dmas_pkg::SrcDec:      next_src = s.work_src - unit_ext;
            dmas_pkg::SrcFixed,
            dmas_pkg::SrcFixedAlt: next_src = s.work_src;
          endcase
          unique case (dst_mode)
            dmas_pkg::DestInc,
            dmas_pkg::DestReload: next_dst = s.work_dst + unit_ext;
            dmas_pkg::DestDec:    next_dst = s.work_dst - unit_ext;
            dmas_pkg::DestFixed:  next_dst = s.work_dst;
          endcase
          s.work_src = next_src;
          s.work_dst = next_dst;

          next_rem    = (s.remaining != '0) ? s.remaining - dmas_pkg::CountW'(1) : s.remaining;
          s.remaining = next_rem;

          if (next_rem == '0) begin
            r.last_of_block = 1'b1;
            s.running       = 1'b0;
            // Repeating timed channels keep advanced src and (unless reload) dst.
            if (cur_ctl[dmas_pkg::RepeatBit] &&
                cur_ctl[dmas_pkg::TimingMsb:dmas_pkg::TimingLsb] !=
                dmas_pkg::TimingImmediate) begin
              s.src[s.run_ch] = next_src;
              if (dst_mode != dmas_pkg::DestReload) begin
                s.dst[s.run_ch] = next_dst;
              end
            end else begin
              s.active[s.run_ch]                      = 1'b0;
              s.ctl[s.run_ch][dmas_pkg::EnableBit]    = 1'b0;
              r.enable_cleared                        = 1'b1;
            end
          end
        end
      end
    endcase

    r.busy_res = s.running || (s.pending != '0);
  end

  assign state_o  = s;
  assign result_o = r;

endmodule

// ----- rtl/dmas_state_regs.sv -----
// Channel register file and working block registers of the DMA sequencer.
// Loads the next state on every accepted beat; depends on dmas_pkg.
`timescale 1ns / 1ps

module dmas_state_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  dmas_pkg::dmas_state_t state_d_i,
  output dmas_pkg::dmas_state_t state_q_o
);

  dmas_pkg::dmas_state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (load_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_q_o = state_q;

endmodule

// ----- rtl/dmas_out_stage.sv -----
// Result register of the DMA sequencer: holds one result beat until it is
// taken, and lets a new beat in when it is empty or being drained. Uses dmas_pkg.
`timescale 1ns / 1ps

module dmas_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  dmas_pkg::dmas_result_t result_i,
  output logic                   space_o,
  dmas_out_if.source             out_o
);

  logic                   valid_q;
  logic                   valid_d;
  dmas_pkg::dmas_result_t result_q;

  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid  = valid_q;
  assign out_o.result = result_q;

endmodule

// ----- rtl/dma_channel_address_sequencer_top.sv -----
// Four-channel DMA address sequencer. Every command beat (set, stop, start
// trigger or step) yields exactly one result beat, registered once it is taken.
// A step issues at most one 16- or 32-bit transfer address pair for the lowest
// pending channel, or for the channel whose block is already running. The
// block takes one beat per clock: the whole channel update is a single
// combinational pass from the state registers into the result register, and
// it only stalls when the result register is full and the sink holds ready low.
// There is no clearing pass after reset.
`timescale 1ns / 1ps

`include "dma_channel_address_sequencer_top_assert.svh"

module dma_channel_address_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmas_in_if.sink     in_i,
  dmas_out_if.source  out_o
);

  dmas_pkg::dmas_state_t  state_q;
  dmas_pkg::dmas_state_t  state_d;
  dmas_pkg::dmas_result_t result_d;
  logic                   space;
  logic                   in_fire;

  assign in_i.ready = space;
  assign in_fire    = in_i.valid && space;

  dmas_step u_step (
    .item_i   (in_i.item),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  dmas_state_regs u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_fire),
    .state_d_i (state_d),
    .state_q_o (state_q)
  );

  dmas_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_fire),
    .result_i (result_d),
    .space_o  (space),
    .out_o    (out_o)
  );

  // A running block always has at least one unit left.
  `DMAS_ASSERT_IMPL(a_run_has_units, state_q.running, state_q.remaining != '0)
  // Only a step beat can produce a transfer.
  `DMAS_ASSERT_NEXT(a_xfer_only_on_step,
                    in_fire && in_i.item.mode != dmas_pkg::ModeStep,
                    !out_o.result.xfer_valid)
  // A step into a running block always issues a transfer.
  `DMAS_ASSERT_NEXT(a_running_step_issues,
                    in_fire && in_i.item.mode == dmas_pkg::ModeStep && state_q.running,
                    out_o.valid && out_o.result.xfer_valid)
  // The enable bit is only cleared on the final beat of a block.
  `DMAS_ASSERT_IMPL(a_clear_at_block_end, out_o.valid && out_o.result.enable_cleared,
                    out_o.result.last_of_block && out_o.result.xfer_valid)

endmodule
